/* sv/sewt_pkg.sv */
// Shared types, register indexes and decision codes of the sleep eligibility wake timer.
package sewt_pkg;

	localparam int CFG_DATA_W = 31;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_THRESH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HB_INTERVAL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RTC_MARGIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SLEEP     = 3'd4;

	localparam logic [4:0] CODE_ELIGIBLE     = 5'd0;
	localparam logic [4:0] CODE_ALWAYS_AWAKE = 5'd1;
	localparam logic [4:0] CODE_BAD_CLOCK    = 5'd2;
	localparam logic [4:0] CODE_IDLE_SHORT   = 5'd3;
	localparam logic [4:0] CODE_BLOCKER_BASE = 5'd4;
	localparam logic [4:0] CODE_BUTTONS_HELD = 5'd20;
	localparam logic [4:0] CODE_DEADLINE_DUE = 5'd21;
	localparam logic [4:0] CODE_WINDOW_SHORT = 5'd22;

	localparam logic [30:0] RST_IDLE_THRESH = 31'd120000;
	localparam logic [16:0] RST_HB_INTERVAL = 17'd3600;

	typedef struct packed {
		logic        battery_mode;
		logic [30:0] idle_threshold_ms;
		logic [16:0] heartbeat_interval_s;
		logic [9:0]  rtc_margin_s;
		logic [11:0] min_sleep_s;
	} sewt_cfg_t;

	typedef struct packed {
		logic [4:0]  code;
		logic [63:0] now;
		logic [64:0] now_m;
		logic [64:0] now_min;
		logic [63:0] cfg_hb;
		logic [63:0] hb;
		logic        hb_zero;
		logic        hb_le_now;
		logic        task_nz;
		logic        task_le_now;
		logic [63:0] tw;
	} sewt_prep_t;

	typedef struct packed {
		logic [4:0]  code;
		logic [63:0] now;
		logic [64:0] now_min;
		logic        hb_zero;
		logic        hb_le_now;
		logic        task_nz;
		logic        task_le_now;
		logic [63:0] tw;
		logic [63:0] hw;
	} sewt_mid_t;

endpackage

/* sv/sewt_prep.sv */
// First decision stage: ordered early checks, deadline sums and task deadline margin.
module sewt_prep import sewt_pkg::*; (
	input  sewt_cfg_t   cfg,
	input  logic        clock_synced,
	input  logic [63:0] rtc_now_s,
	input  logic [15:0] blocker_flags,
	input  logic [31:0] uptime_ms,
	input  logic [31:0] last_activity_ms,
	input  logic        buttons_released,
	input  logic [63:0] heartbeat_due_s,
	input  logic [63:0] task_due_s,
	output sewt_prep_t  prep
);

	logic [31:0] elapsed;
	logic [64:0] cfg_hb;
	logic [64:0] now_m;
	logic [64:0] now_min;
	logic [4:0]  blk_code;
	logic [4:0]  code;

	assign elapsed = uptime_ms - last_activity_ms;
	assign cfg_hb  = {1'b0, rtc_now_s} + 65'(cfg.heartbeat_interval_s);
	assign now_m   = {1'b0, rtc_now_s} + 65'(cfg.rtc_margin_s);
	assign now_min = {1'b0, rtc_now_s} + 65'(cfg.min_sleep_s);

	// lowest set blocker bit wins
	always_comb begin
		blk_code = CODE_BLOCKER_BASE;
		for (int i = 15; i >= 0; i--) begin
			if (blocker_flags[i]) begin
				blk_code = CODE_BLOCKER_BASE + 5'(i);
			end
		end
	end

	always_comb begin
		priority if (!cfg.battery_mode) begin
			code = CODE_ALWAYS_AWAKE;
		end else if (!clock_synced || rtc_now_s == 64'd0) begin
			code = CODE_BAD_CLOCK;
		end else if (blocker_flags != 16'd0) begin
			code = blk_code;
		end else if (elapsed < {1'b0, cfg.idle_threshold_ms}) begin
			code = CODE_IDLE_SHORT;
		end else if (!buttons_released) begin
			code = CODE_BUTTONS_HELD;
		end else if (cfg_hb[64]) begin
			code = CODE_BAD_CLOCK;
		end else begin
			code = CODE_ELIGIBLE;
		end
	end

	assign prep.code        = code;
	assign prep.now         = rtc_now_s;
	assign prep.now_m       = now_m;
	assign prep.now_min     = now_min;
	assign prep.cfg_hb      = cfg_hb[63:0];
	assign prep.hb          = heartbeat_due_s;
	assign prep.hb_zero     = heartbeat_due_s == 64'd0;
	assign prep.hb_le_now   = heartbeat_due_s <= rtc_now_s;
	assign prep.task_nz     = task_due_s != 64'd0;
	assign prep.task_le_now = task_due_s <= rtc_now_s;
	assign prep.tw          = ({1'b0, task_due_s} > now_m) ?
		(task_due_s - 64'(cfg.rtc_margin_s)) : rtc_now_s;

endmodule

/* sv/sleep_eligibility_wake_timer_core.sv */
// Top level of the sleep eligibility wake timer: config registers and four-stage decision pipe.
// Path: a transaction passes the input register, then the prep, mid and result registers, where rsp_valid shows it.
// Throughput: one transaction per cycle; the pipe advances stage by stage under rsp_stall.
// Stages: input register, early checks and sums, heartbeat clamp and margin, result register.
// Reset: arst_n empties the pipe at once and loads the config registers with their defaults.
// Config writes take effect on the next edge and are meant to be made while the pipe is empty.
module sleep_eligibility_wake_timer_core import sewt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic                  clock_synced,
	input  logic [63:0]           rtc_now_s,
	input  logic [15:0]           blocker_flags,
	input  logic [31:0]           uptime_ms,
	input  logic [31:0]           last_activity_ms,
	input  logic                  buttons_released,
	input  logic [63:0]           heartbeat_due_s,
	input  logic [63:0]           task_due_s,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic                  may_sleep,
	output logic [4:0]            decision_code,
	output logic [63:0]           wake_time_s
);

	sewt_cfg_t cfg_q;

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic        adv_s1, adv_s2, adv_s3, adv_s4;

	logic        synced_s1;
	logic [63:0] now_s1;
	logic [15:0] blk_s1;
	logic [31:0] up_s1;
	logic [31:0] last_s1;
	logic        rel_s1;
	logic [63:0] hb_s1;
	logic [63:0] task_s1;

	sewt_prep_t  prep_d, prep_s2;
	sewt_mid_t   mid_d, mid_s3;

	logic [63:0] hb_eff;
	logic [63:0] at;
	logic [4:0]  code_d;

	logic        may_sleep_s4;
	logic [4:0]  code_s4;
	logic [63:0] wake_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.battery_mode         <= 1'b0;
			cfg_q.idle_threshold_ms    <= RST_IDLE_THRESH;
			cfg_q.heartbeat_interval_s <= RST_HB_INTERVAL;
			cfg_q.rtc_margin_s         <= '0;
			cfg_q.min_sleep_s          <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BATTERY_MODE: cfg_q.battery_mode         <= cfg_data[0];
				CFG_IDLE_THRESH:  cfg_q.idle_threshold_ms    <= cfg_data[30:0];
				CFG_HB_INTERVAL:  cfg_q.heartbeat_interval_s <= cfg_data[16:0];
				CFG_RTC_MARGIN:   cfg_q.rtc_margin_s         <= cfg_data[9:0];
				CFG_MIN_SLEEP:    cfg_q.min_sleep_s          <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	assign adv_s4    = !valid_s4 || !rsp_stall;
	assign adv_s3    = !valid_s3 || adv_s4;
	assign adv_s2    = !valid_s2 || adv_s3;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= req_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			synced_s1 <= clock_synced;
			now_s1    <= rtc_now_s;
			blk_s1    <= blocker_flags;
			up_s1     <= uptime_ms;
			last_s1   <= last_activity_ms;
			rel_s1    <= buttons_released;
			hb_s1     <= heartbeat_due_s;
			task_s1   <= task_due_s;
		end
	end

	sewt_prep u_prep (
		.cfg              (cfg_q),
		.clock_synced     (synced_s1),
		.rtc_now_s        (now_s1),
		.blocker_flags    (blk_s1),
		.uptime_ms        (up_s1),
		.last_activity_ms (last_s1),
		.buttons_released (rel_s1),
		.heartbeat_due_s  (hb_s1),
		.task_due_s       (task_s1),
		.prep             (prep_d)
	);

	always_ff @(posedge clk) begin
		if (adv_s2) prep_s2 <= prep_d;
	end

	// clamp the heartbeat to now + interval (a zero heartbeat takes that too), then take the margin off, not below now
	assign hb_eff = (prep_s2.hb_zero || prep_s2.hb > prep_s2.cfg_hb) ?
		prep_s2.cfg_hb : prep_s2.hb;

	always_comb begin
		mid_d.code        = prep_s2.code;
		mid_d.now         = prep_s2.now;
		mid_d.now_min     = prep_s2.now_min;
		mid_d.hb_zero     = prep_s2.hb_zero;
		mid_d.hb_le_now   = prep_s2.hb_le_now;
		mid_d.task_nz     = prep_s2.task_nz;
		mid_d.task_le_now = prep_s2.task_le_now;
		mid_d.tw          = prep_s2.tw;
		mid_d.hw          = ({1'b0, hb_eff} > prep_s2.now_m) ?
			(hb_eff - 64'(cfg_q.rtc_margin_s)) : prep_s2.now;
	end

	always_ff @(posedge clk) begin
		if (adv_s3) mid_s3 <= mid_d;
	end

	assign at = (mid_s3.task_nz && mid_s3.tw < mid_s3.hw) ? mid_s3.tw : mid_s3.hw;

	always_comb begin
		priority if (mid_s3.code != CODE_ELIGIBLE) begin
			code_d = mid_s3.code;
		end else if (!mid_s3.hb_zero && mid_s3.hb_le_now) begin
			code_d = CODE_DEADLINE_DUE;
		end else if (mid_s3.task_nz && mid_s3.task_le_now) begin
			code_d = CODE_DEADLINE_DUE;
		end else if (at <= mid_s3.now) begin
			code_d = CODE_DEADLINE_DUE;
		end else if ({1'b0, at} < mid_s3.now_min) begin
			code_d = CODE_WINDOW_SHORT;
		end else begin
			code_d = CODE_ELIGIBLE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			may_sleep_s4 <= code_d == CODE_ELIGIBLE;
			code_s4      <= code_d;
			wake_s4      <= (code_d == CODE_ELIGIBLE) ? at : 64'd0;
		end
	end

	assign rsp_valid     = valid_s4;
	assign may_sleep     = may_sleep_s4;
	assign decision_code = code_s4;
	assign wake_time_s   = wake_s4;

	a_sleep_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (may_sleep == (decision_code == CODE_ELIGIBLE)))
		else $error("may_sleep disagrees with decision_code");

	a_wake_zero_when_awake: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !may_sleep |-> wake_time_s == 64'd0)
		else $error("wake time set on a refused transaction");

	a_wake_armed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && may_sleep |-> wake_time_s != 64'd0)
		else $error("sleep granted with no wake time");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> decision_code <= CODE_WINDOW_SHORT)
		else $error("decision code out of range");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && valid_s2 && valid_s3 && valid_s4 && rsp_stall)
		else $error("request stalled while the pipe has room");

endmodule
